[rtl/core/mrld_pkg.sv]
// Morse run-length decoder: shared types, element codes, status codes and the
// letter code table with its characters.
// Depends on nothing; mrld_code_match and the top level import it.
`default_nettype none

package mrld_pkg;

	localparam int CODE_ENTRIES = 40;
	localparam int CODE_LENGTH  = 6;
	localparam int ENTRY_W      = $clog2(CODE_ENTRIES);
	localparam int GIDX_W       = $clog2(CODE_LENGTH);
	localparam int RUN_W        = 17;
	localparam int MAG_W        = 17;

	localparam logic [1:0] EL_NONE = 2'd0;
	localparam logic [1:0] EL_DOT  = 2'd1;
	localparam logic [1:0] EL_DASH = 2'd2;

	localparam logic [7:0] CHAR_STAR = "*";
	localparam logic [7:0] CHAR_FILL = "_";

	typedef logic [1:0] elem_t;
	typedef elem_t [0:CODE_LENGTH-1] group_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNKNOWN  = 2'd1,
		ST_TOO_MANY = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// Element 0 of each row is the first element of the letter.
	localparam group_t CODE_TABLE [CODE_ENTRIES] = '{
		'{2'd1, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0}, '{2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0},
		'{2'd2, 2'd1, 2'd2, 2'd1, 2'd0, 2'd0}, '{2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0},
		'{2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0}, '{2'd1, 2'd1, 2'd2, 2'd1, 2'd0, 2'd0},
		'{2'd2, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0}, '{2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0},
		'{2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0}, '{2'd1, 2'd2, 2'd2, 2'd2, 2'd0, 2'd0},
		'{2'd2, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0}, '{2'd1, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0},
		'{2'd2, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0}, '{2'd2, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd2, 2'd2, 2'd2, 2'd0, 2'd0, 2'd0}, '{2'd1, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0},
		'{2'd1, 2'd2, 2'd1, 2'd2, 2'd0, 2'd0}, '{2'd1, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0},
		'{2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0}, '{2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0}, '{2'd1, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0},
		'{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd0}, '{2'd2, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0},
		'{2'd2, 2'd1, 2'd2, 2'd2, 2'd0, 2'd0}, '{2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0},
		'{2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2}, '{2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd2},
		'{2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1}, '{2'd2, 2'd1, 2'd1, 2'd2, 2'd1, 2'd0},
		'{2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0}, '{2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd0},
		'{2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd0}, '{2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd0},
		'{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0}, '{2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0},
		'{2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd0}, '{2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0},
		'{2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0}, '{2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0}
	};

	localparam logic [7:0] CODE_CHARS [CODE_ENTRIES] = '{
		"a", "b", "c", "d", "e", "f", "g", "h", "i", "j",
		"k", "l", "m", "n", "o", "p", "q", "r", "s", "t",
		"u", "v", "w", "x", "y", "z", ".", ",", "?", "/",
		"1", "2", "3", "4", "5", "6", "7", "8", "9", "0"
	};

endpackage

`default_nettype wire

[rtl/core/mrld_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module mrld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/core/mrld_code_match.sv]
// Compares the collected element group against one row of the letter table.
// Depends on mrld_pkg (table, characters, group type).
`default_nettype none

module mrld_code_match
	import mrld_pkg::*;
(
	input  wire group_t             grp,
	input  wire logic [ENTRY_W-1:0] entry,
	output logic                    hit,
	output logic [7:0]              char_code
);

	always_comb begin
		hit       = (grp == CODE_TABLE[entry]);
		char_code = CODE_CHARS[entry];
	end

endmodule

`default_nettype wire

[rtl/core/morse_run_length_decoder_unit.sv]
// Morse run-length decoder, top level. Uses mrld_pkg, mrld_ram and mrld_code_match.
// Loads one message of signed runs, decodes it and sends out the text.
`default_nettype none

// A message arrives as signed run lengths, one item per cycle, positive for a
// mark and negative for a gap; the first item of each message is dropped and a
// zero run is ignored, but last_run is always obeyed. Runs beyond MAX_RUNS are
// dropped and flag status 3. After the item carrying last_run the block stalls
// its input and decodes: each stored run passes three steps (RAM read, one
// shared multiply of run by the count of its kind, one compare against the sum
// of its kind), and each letter close has one comparator walk the code table
// one row per cycle, over at most 40 rows. The text then leaves as MAX_CHARS
// items, each through a text RAM read, and any output stall holds it.
// Unfilled positions read '_', an unmatched letter reads '*'; every item of a
// message carries the same status. No clearing pass is needed after reset.
module morse_run_length_decoder_unit
	import mrld_pkg::*;
#(
	parameter int MAX_RUNS  = 256,
	parameter int MAX_CHARS = 4
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    run_valid,
	output logic                         run_stall,
	input  wire logic signed [RUN_W-1:0] run_length,
	input  wire logic                    last_run,
	output logic                         char_valid,
	input  wire logic                    char_stall,
	output logic [7:0]                   char_code,
	output logic [1:0]                   status,
	output logic                         last_char
);

	localparam int RA_W  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int CNT_W = $clog2(MAX_RUNS + 1);
	localparam int SUM_W = MAG_W + CNT_W;
	localparam int CA_W  = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
	localparam int CC_W  = $clog2(MAX_CHARS + 1);

	typedef enum logic [2:0] {
		S_LOAD,
		S_RD,
		S_MUL,
		S_CMP,
		S_MATCH,
		S_ERD,
		S_EOUT
	} state_t;

	state_t               state_q;
	logic                 started_q;
	logic                 overflow_q;
	logic [CNT_W-1:0]     run_count_q;
	logic [SUM_W-1:0]     mark_sum_q;
	logic [CNT_W-1:0]     mark_count_q;
	logic [SUM_W-1:0]     gap_sum_q;
	logic [CNT_W-1:0]     gap_count_q;
	group_t               group_q;
	logic [7:0]           group_len_q;
	logic [CC_W-1:0]      char_count_q;
	logic                 star_q;
	status_t              status_q;
	logic [RA_W-1:0]      idx_q;
	logic                 final_q;
	logic [ENTRY_W-1:0]   entry_q;
	logic [SUM_W-1:0]     prod_q;
	logic                 gap_q;
	logic [CA_W-1:0]      emit_q;
	logic                 char_valid_q;
	logic [7:0]           char_code_q;
	logic [1:0]           status_q_out;
	logic                 last_char_q;

	// Load side
	logic                 run_accept;
	logic                 store_ok;
	logic                 in_gap;
	logic [MAG_W-1:0]     in_mag;
	logic [CNT_W-1:0]     rc_next;

	// Decode side
	logic [RUN_W-1:0]     run_rdata;
	logic                 rd_gap;
	logic [MAG_W-1:0]     rd_mag;
	logic [CNT_W-1:0]     rd_cnt;
	logic                 cut_ge;
	logic [CNT_W-1:0]     idx_next;
	logic                 walk_done;
	logic                 text_full;
	logic                 hit;
	logic [7:0]           hit_char;
	logic                 txt_we;
	logic [7:0]           txt_rdata;
	logic                 out_free;
	logic [CC_W-1:0]      emit_ext;
	logic [7:0]           emit_char;
	logic                 emit_last;
	elem_t                new_elem;

	always_comb begin
		run_accept = run_valid && !run_stall;
		in_gap     = run_length[RUN_W-1];
		in_mag     = in_gap ? MAG_W'(-run_length) : MAG_W'(run_length);
		store_ok   = started_q && (run_length != '0) && (run_count_q < CNT_W'(MAX_RUNS));
		rc_next    = run_count_q + CNT_W'(store_ok);

		rd_gap     = run_rdata[RUN_W-1];
		rd_mag     = rd_gap ? MAG_W'(-$signed(run_rdata)) : MAG_W'(run_rdata);
		rd_cnt     = rd_gap ? gap_count_q : mark_count_q;
		cut_ge     = prod_q >= (gap_q ? gap_sum_q : mark_sum_q);
		new_elem   = cut_ge ? EL_DASH : EL_DOT;
		idx_next   = CNT_W'(idx_q) + CNT_W'(1);
		walk_done  = (idx_next == run_count_q);

		text_full  = (char_count_q >= CC_W'(MAX_CHARS));
		txt_we     = (state_q == S_MATCH) && !text_full && hit;

		out_free   = !char_valid_q || !char_stall;
		emit_ext   = CC_W'(emit_q);
		emit_last  = (emit_q == CA_W'(MAX_CHARS - 1));
		if (emit_ext < char_count_q) begin
			emit_char = txt_rdata;
		end else if ((emit_ext == char_count_q) && star_q) begin
			emit_char = CHAR_STAR;
		end else begin
			emit_char = CHAR_FILL;
		end
	end

	mrld_ram #(
		.WIDTH(RUN_W),
		.DEPTH(MAX_RUNS)
	) u_run_ram (
		.clk  (clk),
		.we   (run_accept && store_ok),
		.waddr(run_count_q[RA_W-1:0]),
		.wdata(run_length),
		.raddr(idx_q),
		.rdata(run_rdata)
	);

	mrld_ram #(
		.WIDTH(8),
		.DEPTH(MAX_CHARS)
	) u_text_ram (
		.clk  (clk),
		.we   (txt_we),
		.waddr(char_count_q[CA_W-1:0]),
		.wdata(hit_char),
		.raddr(emit_q),
		.rdata(txt_rdata)
	);

	mrld_code_match u_match (
		.grp      (group_q),
		.entry    (entry_q),
		.hit      (hit),
		.char_code(hit_char)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			started_q    <= 1'b0;
			overflow_q   <= 1'b0;
			run_count_q  <= '0;
			mark_sum_q   <= '0;
			mark_count_q <= '0;
			gap_sum_q    <= '0;
			gap_count_q  <= '0;
			group_q      <= '0;
			group_len_q  <= '0;
			char_count_q <= '0;
			star_q       <= 1'b0;
			status_q     <= ST_OK;
			idx_q        <= '0;
			final_q      <= 1'b0;
			entry_q      <= '0;
			prod_q       <= '0;
			gap_q        <= 1'b0;
			emit_q       <= '0;
			char_valid_q <= 1'b0;
			char_code_q  <= '0;
			status_q_out <= '0;
			last_char_q  <= 1'b0;
		end else begin
			// Drop the output item once taken, unless the emit state reloads it.
			if (char_valid_q && !char_stall && (state_q != S_EOUT)) begin
				char_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_LOAD: begin
					if (run_accept) begin
						started_q <= 1'b1;
						if (store_ok) begin
							run_count_q <= rc_next;
							if (in_gap) begin
								gap_sum_q   <= gap_sum_q + SUM_W'(in_mag);
								gap_count_q <= gap_count_q + CNT_W'(1);
							end else begin
								mark_sum_q   <= mark_sum_q + SUM_W'(in_mag);
								mark_count_q <= mark_count_q + CNT_W'(1);
							end
						end else if (started_q && (run_length != '0)) begin
							overflow_q <= 1'b1;
						end
						if (last_run) begin
							idx_q   <= '0;
							entry_q <= '0;
							// An empty message goes straight to the final close.
							if (rc_next == '0) begin
								final_q <= 1'b1;
								state_q <= S_MATCH;
							end else begin
								final_q <= 1'b0;
								state_q <= S_RD;
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= SUM_W'(rd_mag) * SUM_W'(rd_cnt);
					gap_q   <= rd_gap;
					state_q <= S_CMP;
				end
				S_CMP: begin
					entry_q <= '0;
					if (gap_q && cut_ge) begin
						// Long gap: close the letter, resume the walk afterwards.
						final_q <= 1'b0;
						state_q <= S_MATCH;
					end else begin
						if (!gap_q) begin
							if (group_len_q < 8'(CODE_LENGTH)) begin
								group_q[group_len_q[GIDX_W-1:0]] <= new_elem;
							end
							if (group_len_q != 8'hFF) begin
								group_len_q <= group_len_q + 8'd1;
							end
						end
						if (walk_done) begin
							final_q <= 1'b1;
							state_q <= S_MATCH;
						end else begin
							idx_q   <= idx_q + RA_W'(1);
							state_q <= S_RD;
						end
					end
				end
				S_MATCH: begin
					if (text_full) begin
						status_q <= ST_TOO_MANY;
						emit_q   <= '0;
						state_q  <= S_ERD;
					end else if (hit) begin
						group_q      <= '0;
						group_len_q  <= '0;
						char_count_q <= char_count_q + CC_W'(1);
						entry_q      <= '0;
						if (final_q) begin
							emit_q  <= '0;
							state_q <= S_ERD;
						end else if (walk_done) begin
							final_q <= 1'b1;
						end else begin
							idx_q   <= idx_q + RA_W'(1);
							state_q <= S_RD;
						end
					end else if (entry_q == ENTRY_W'(CODE_ENTRIES - 1)) begin
						star_q   <= 1'b1;
						status_q <= ST_UNKNOWN;
						emit_q   <= '0;
						state_q  <= S_ERD;
					end else begin
						entry_q <= entry_q + ENTRY_W'(1);
					end
				end
				S_ERD: begin
					state_q <= S_EOUT;
				end
				S_EOUT: begin
					if (out_free) begin
						char_valid_q <= 1'b1;
						char_code_q  <= emit_char;
						status_q_out <= overflow_q ? ST_OVERFLOW : status_q;
						last_char_q  <= emit_last;
						if (emit_last) begin
							// Message done: return all message state to reset.
							started_q    <= 1'b0;
							overflow_q   <= 1'b0;
							run_count_q  <= '0;
							mark_sum_q   <= '0;
							mark_count_q <= '0;
							gap_sum_q    <= '0;
							gap_count_q  <= '0;
							group_q      <= '0;
							group_len_q  <= '0;
							char_count_q <= '0;
							star_q       <= 1'b0;
							status_q     <= ST_OK;
							state_q      <= S_LOAD;
						end else begin
							emit_q  <= emit_q + CA_W'(1);
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_comb begin
		run_stall  = (state_q != S_LOAD);
		char_valid = char_valid_q;
		char_code  = char_code_q;
		status     = status_q_out;
		last_char  = last_char_q;
	end

endmodule

`default_nettype wire

[rtl/core/mrld_checker.sv]
// Port-level checks for the Morse run-length decoder and their bind to the top.
// Depends on morse_run_length_decoder_unit.
`default_nettype none

module mrld_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        run_valid,
	input wire logic        run_stall,
	input wire logic        last_run,
	input wire logic        char_valid,
	input wire logic        char_stall,
	input wire logic [7:0]  char_code,
	input wire logic [1:0]  status,
	input wire logic        last_char
);

	// A stalled output item holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(char_code)
			&& $stable(status) && $stable(last_char))
		else $error("output item changed while stalled");

	// The last run of a message starts the decode, so input stalls next.
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && !run_stall && last_run |=> run_stall)
		else $error("input not stalled after last run");

	// Mid-text items are sent while the input is still held off.
	a_text_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !last_char |-> run_stall)
		else $error("input taken while text still being sent");

endmodule

bind morse_run_length_decoder_unit mrld_checker u_mrld_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.run_valid (run_valid),
	.run_stall (run_stall),
	.last_run  (last_run),
	.char_valid(char_valid),
	.char_stall(char_stall),
	.char_code (char_code),
	.status    (status),
	.last_char (last_char)
);

`default_nettype wire
